>>> hdl/directed_hausdorff_distance_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef DIRECTED_HAUSDORFF_DISTANCE_MACROS_SVH
`define DIRECTED_HAUSDORFF_DISTANCE_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define DHD_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("directed_hausdorff_distance: assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define DHD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("directed_hausdorff_distance: forbidden condition seen");

`else

`define DHD_ASSERT_AT(lbl, clk, rst_n, prop)
`define DHD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hdl/dhd_pkg.sv
`timescale 1ns / 1ps

package dhd_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 11;

  localparam int ACTION_W = 2;
  localparam int IN_COORD_W = 11;
  localparam int DIST_W = 24;

  localparam logic [DIST_W-1:0] MAX_VALUE_RESET = 24'd8380418;
  localparam logic [DIST_W-1:0] DIST_SAT = 24'hFFFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_APPEND_A = 2'd1,
    ACT_APPEND_B = 2'd2,
    ACT_COMPUTE  = 2'd3
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append_a;
    logic append_b;
    logic start;
    logic worst_max;
    logic rd;
    logic mult;
    logic eval;
    logic load_out;
  } dhd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic last_i;
    logic inner_done;
    logic out_busy;
  } dhd_status_t;

endpackage

>>> hdl/dhd_ctrl.sv
`timescale 1ns / 1ps

module dhd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  dhd_pkg::action_e      in_action_i,
  output logic                  in_ready_o,
  input  dhd_pkg::dhd_status_t  status_i,
  output dhd_pkg::dhd_cmd_t     cmd_o
);
  import dhd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_MULT,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clear     = accept && (in_action_i == ACT_CLEAR);
    cmd_o.append_a  = accept && (in_action_i == ACT_APPEND_A);
    cmd_o.append_b  = accept && (in_action_i == ACT_APPEND_B);
    cmd_o.start     = (state_q == S_START);
    cmd_o.worst_max = (state_q == S_START) && !status_i.a_empty && status_i.b_empty;
    cmd_o.rd        = (state_q == S_READ);
    cmd_o.mult      = (state_q == S_MULT);
    cmd_o.eval      = (state_q == S_EVAL);
    cmd_o.load_out  = (state_q == S_DONE) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && (in_action_i == ACT_COMPUTE)) begin
            state_q <= S_START;
            ready_q <= 1'b0;
          end
        end
        S_START: begin
          // An empty set on either side settles the result right away.
          if (status_i.a_empty || status_i.b_empty) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_MULT;
        end
        S_MULT: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (status_i.inner_done && status_i.last_i) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (!status_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hdl/dhd_datapath.sv
`timescale 1ns / 1ps

module dhd_datapath #(
  parameter int MAX_POINTS = dhd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = dhd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dhd_pkg::DIST_W-1:0]      cfg_wdata_i,
  input  logic [dhd_pkg::IN_COORD_W-1:0]  in_x_i,
  input  logic [dhd_pkg::IN_COORD_W-1:0]  in_y_i,
  input  dhd_pkg::dhd_cmd_t               cmd_i,
  output dhd_pkg::dhd_status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dhd_pkg::DIST_W-1:0]      out_dist_o,
  output logic                            out_dropped_o
);
  import dhd_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int XW     = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int PW     = 2 * COORD_BITS;
  localparam int DW     = 2 * COORD_BITS + 1;
  localparam int CW     = (DW > DIST_W) ? DW : DIST_W;

  // One stored point: y in the upper half, x in the lower half.
  logic [PW-1:0] mem_a [MAX_POINTS];
  logic [PW-1:0] mem_b [MAX_POINTS];
  logic [PW-1:0] rd_a_q;
  logic [PW-1:0] rd_b_q;

  logic [DIST_W-1:0] max_value_q;
  logic [CNT_W-1:0]  count_a_q;
  logic [CNT_W-1:0]  count_b_q;
  logic              dropped_q;
  logic              full_a;
  logic              full_b;

  logic [ADDR_W-1:0] i_q;
  logic [ADDR_W-1:0] j_q;
  logic              last_i;
  logic              last_j;

  logic [XW-1:0]         x_w;
  logic [XW-1:0]         y_w;
  logic [PW-1:0]         wr_point;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] dx, dy;
  logic [PW-1:0]         sqx_q;
  logic [PW-1:0]         sqy_q;
  logic [CW-1:0]         pair_dist;
  logic [CW-1:0]         nearest_q;
  logic [CW-1:0]         nearest_new;
  logic [CW-1:0]         worst_q;
  logic [CW-1:0]         worst_new;
  logic                  brk;
  logic                  inner_done;
  logic                  out_valid_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic                  out_dropped_q;

  assign x_w      = XW'(in_x_i);
  assign y_w      = XW'(in_y_i);
  assign wr_point = {y_w[COORD_BITS-1:0], x_w[COORD_BITS-1:0]};

  assign full_a = (count_a_q == CNT_W'(MAX_POINTS));
  assign full_b = (count_b_q == CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.append_a && !full_a) begin
      mem_a[count_a_q[ADDR_W-1:0]] <= wr_point;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem_a[i_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append_b && !full_b) begin
      mem_b[count_b_q[ADDR_W-1:0]] <= wr_point;
    end
    if (cmd_i.rd) begin
      rd_b_q <= mem_b[j_q];
    end
  end

  assign ax = rd_a_q[COORD_BITS-1:0];
  assign ay = rd_a_q[PW-1:COORD_BITS];
  assign bx = rd_b_q[COORD_BITS-1:0];
  assign by = rd_b_q[PW-1:COORD_BITS];
  assign dx = (ax > bx) ? (ax - bx) : (bx - ax);
  assign dy = (ay > by) ? (ay - by) : (by - ay);

  assign pair_dist   = CW'(sqx_q) + CW'(sqy_q);
  assign nearest_new = (pair_dist < nearest_q) ? pair_dist : nearest_q;
  // A point of A closer than the current maximum can no longer raise it.
  assign brk         = (pair_dist < worst_q);
  assign last_j      = (CNT_W'(j_q) == count_b_q - CNT_W'(1));
  assign last_i      = (CNT_W'(i_q) == count_a_q - CNT_W'(1));
  assign inner_done  = brk || last_j;
  assign worst_new   = (nearest_new > worst_q) ? nearest_new : worst_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      sqx_q <= PW'(dx) * PW'(dx);
      sqy_q <= PW'(dy) * PW'(dy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RESET;
      count_a_q   <= '0;
      count_b_q   <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_value_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        count_a_q <= '0;
        count_b_q <= '0;
        dropped_q <= 1'b0;
      end
      if (cmd_i.append_a) begin
        if (full_a) begin
          dropped_q <= 1'b1;
        end else begin
          count_a_q <= count_a_q + CNT_W'(1);
        end
      end
      if (cmd_i.append_b) begin
        if (full_b) begin
          dropped_q <= 1'b1;
        end else begin
          count_b_q <= count_b_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search registers for the nested loop over A and B.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      i_q       <= '0;
      j_q       <= '0;
      nearest_q <= CW'(max_value_q);
      worst_q   <= cmd_i.worst_max ? CW'(max_value_q) : '0;
    end else if (cmd_i.eval) begin
      if (inner_done) begin
        worst_q   <= worst_new;
        nearest_q <= CW'(max_value_q);
        i_q       <= i_q + ADDR_W'(1);
        j_q       <= '0;
      end else begin
        nearest_q <= nearest_new;
        j_q       <= j_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_dist_q    <= (worst_q > CW'(DIST_SAT)) ? DIST_SAT : worst_q[DIST_W-1:0];
      out_dropped_q <= dropped_q;
    end
  end

  assign status_o.a_empty    = (count_a_q == '0);
  assign status_o.b_empty    = (count_b_q == '0);
  assign status_o.last_i     = last_i;
  assign status_o.inner_done = inner_done;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_dist_o    = out_dist_q;
  assign out_dropped_o = out_dropped_q;

endmodule

>>> hdl/directed_hausdorff_distance.sv
`timescale 1ns / 1ps
`include "directed_hausdorff_distance_macros.svh"

// Directed squared Hausdorff distance from point set A to point set B. Each
// request carries an action in tuser: clear both sets, append (x, y) to A,
// append (x, y) to B, or compute. Clear and append requests produce no
// result; an append to a full set is dropped and flagged in the result's
// tuser until the next clear. A compute request walks A and, for each point,
// searches B for the nearest point, stopping that search as soon as a
// distance falls below the running maximum. Every step of that search reads
// both point memories, squares the differences in a registered multiplier
// stage and then compares. Before its result is loaded, a compute also waits
// for the previous result to be taken. An empty A gives 0 and an empty B
// gives max_value. No request is taken while a compute runs. The point
// memories are not cleared at reset; only entries below each set's count are
// ever read. The max_value register is written through cfg_we_i.
module directed_hausdorff_distance #(
  parameter int MAX_POINTS = dhd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = dhd_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dhd_pkg::DIST_W-1:0]       cfg_wdata_i,     // max_value
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [23:0]                      s_axis_tdata_i,  // x[10:0], y[21:11], zero pad
  input  logic [dhd_pkg::ACTION_W-1:0]     s_axis_tuser_i,  // action
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [dhd_pkg::DIST_W-1:0]       m_axis_tdata_o,  // distance_sq
  output logic                             m_axis_tuser_o   // points_dropped
);
  import dhd_pkg::*;

  dhd_cmd_t    cmd;
  dhd_status_t status;
  action_e     action;

  assign action = action_e'(s_axis_tuser_i);

  dhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (action),
    .in_ready_o  (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dhd_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_x_i        (s_axis_tdata_i[IN_COORD_W-1:0]),
    .in_y_i        (s_axis_tdata_i[2*IN_COORD_W-1:IN_COORD_W]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_dist_o    (m_axis_tdata_o),
    .out_dropped_o (m_axis_tuser_o)
  );

  // A waiting result is never overwritten by a new one.
  `DHD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load_out && status.out_busy)

  // A compute request closes the input until its result is loaded.
  `DHD_ASSERT_AT(a_compute_blocks, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_COMPUTE)) |=> !s_axis_tready_o)

  // A loaded result shows up on the output in the next cycle.
  `DHD_ASSERT_AT(a_load_shows, clk_i, rst_ni, cmd.load_out |=> m_axis_tvalid_o)

endmodule
